>>> sv/i2f_pkg.sv
// Shared types and constants for the integer to floating-point converter.
// Used by the front, queue, back and top-level modules; depends on nothing.
package i2f_pkg;

    // Conversion modes carried on func.
    typedef enum logic [1:0] {
        FUNC_S_TO_D = 2'd0,
        FUNC_U_TO_D = 2'd1,
        FUNC_S_TO_S = 2'd2,
        FUNC_U_TO_S = 2'd3
    } func_t;

    localparam int INT_W       = 64;
    localparam int NORM_W      = 6;
    localparam int DBL_MANT_W  = 52;
    localparam int DBL_EXP_W   = 11;
    localparam int DBL_BIAS    = 1023;
    localparam int SGL_MANT_W  = 23;
    localparam int SGL_EXP_W   = 8;
    localparam int SGL_BIAS    = 127;
    localparam int QUEUE_DEPTH = 2;

    // One classified request on its way from the front to the back.
    typedef struct packed {
        logic             neg;
        logic             single;
        logic [INT_W-1:0] mag;
    } i2f_item_t;

endpackage

>>> sv/i2f_front.sv
// Front end: classifies a request by mode and forms the sign and magnitude.
// Depends on i2f_pkg.
module i2f_front (
    input  logic [1:0]                 func,
    input  logic [i2f_pkg::INT_W-1:0]  int_value,
    output i2f_pkg::i2f_item_t         item
);

    logic is_signed;
    logic single;
    logic neg;

    always_comb
    begin
        unique case (func)
            i2f_pkg::FUNC_S_TO_D:
            begin
                is_signed = 1'b1;
                single    = 1'b0;
            end
            i2f_pkg::FUNC_U_TO_D:
            begin
                is_signed = 1'b0;
                single    = 1'b0;
            end
            i2f_pkg::FUNC_S_TO_S:
            begin
                is_signed = 1'b1;
                single    = 1'b1;
            end
            default:
            begin
                is_signed = 1'b0;
                single    = 1'b1;
            end
        endcase
    end

    // The most negative value negates to itself, which read unsigned is 2^63.
    assign neg         = is_signed & int_value[i2f_pkg::INT_W-1];
    assign item.neg    = neg;
    assign item.single = single;
    assign item.mag    = neg ? (~int_value + i2f_pkg::INT_W'(1)) : int_value;

endmodule

>>> sv/i2f_queue.sv
// Short queue of classified requests between the front and the back.
// Depends on i2f_pkg for the item type.
module i2f_queue #(
    parameter int DEPTH = i2f_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  i2f_pkg::i2f_item_t push_item,
    input  logic               pop,
    output i2f_pkg::i2f_item_t head_item,
    output logic               empty,
    output logic               full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    i2f_pkg::i2f_item_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign empty     = (count_reg == CW'(0));
    assign full      = (count_reg == CW'(DEPTH));
    assign head_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !(push && !pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("queue read while empty");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("queue count did not follow a lone write");

endmodule

>>> sv/i2f_back.sv
// Back end: normalizes the magnitude over two stages, then rounds to nearest
// even and packs the binary64 or binary32 pattern. Depends on i2f_pkg.
module i2f_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  i2f_pkg::i2f_item_t         in_item,
    output logic                       done,
    output logic [i2f_pkg::INT_W-1:0]  float_bits
);

    localparam int W  = i2f_pkg::INT_W;
    localparam int NW = i2f_pkg::NORM_W;
    localparam int DM = i2f_pkg::DBL_MANT_W;
    localparam int DE = i2f_pkg::DBL_EXP_W;
    localparam int SM = i2f_pkg::SGL_MANT_W;
    localparam int SE = i2f_pkg::SGL_EXP_W;
    localparam int DG = W - 2 - DM;
    localparam int SG = W - 2 - SM;

    // Stage 1: coarse shifts by 32, 16 and 8.
    logic          s1_valid_reg;
    logic          s1_neg_reg;
    logic          s1_single_reg;
    logic          s1_zero_reg;
    logic [W-1:0]  s1_x_reg;
    logic [NW-1:0] s1_n_reg;

    // Stage 2: fine shifts by 4, 2 and 1.
    logic          s2_valid_reg;
    logic          s2_neg_reg;
    logic          s2_single_reg;
    logic          s2_zero_reg;
    logic [W-1:0]  s2_x_reg;
    logic [NW-1:0] s2_n_reg;

    logic          done_reg;
    logic [W-1:0]  float_bits_reg;

    logic [W-1:0]  s1_x_next;
    logic [NW-1:0] s1_n_next;
    logic [W-1:0]  s2_x_next;
    logic [NW-1:0] s2_n_next;
    logic [W-1:0]  float_bits_next;

    always_comb
    begin
        s1_x_next = in_item.mag;
        s1_n_next = '0;
        if (s1_x_next[W-1 -: 32] == '0)
        begin
            s1_x_next = s1_x_next << 32;
            s1_n_next = s1_n_next + NW'(32);
        end
        if (s1_x_next[W-1 -: 16] == '0)
        begin
            s1_x_next = s1_x_next << 16;
            s1_n_next = s1_n_next + NW'(16);
        end
        if (s1_x_next[W-1 -: 8] == '0)
        begin
            s1_x_next = s1_x_next << 8;
            s1_n_next = s1_n_next + NW'(8);
        end
    end

    always_comb
    begin
        s2_x_next = s1_x_reg;
        s2_n_next = s1_n_reg;
        if (s2_x_next[W-1 -: 4] == '0)
        begin
            s2_x_next = s2_x_next << 4;
            s2_n_next = s2_n_next + NW'(4);
        end
        if (s2_x_next[W-1 -: 2] == '0)
        begin
            s2_x_next = s2_x_next << 2;
            s2_n_next = s2_n_next + NW'(2);
        end
        if (s2_x_next[W-1] == 1'b0)
        begin
            s2_x_next = s2_x_next << 1;
            s2_n_next = s2_n_next + NW'(1);
        end
    end

    // Rounding: round up when the guard bit is set and either a lower bit is
    // set or the kept mantissa is odd. A carry out of the mantissa lands in
    // the exponent through the small add.
    logic          d_up;
    logic [DM:0]   d_rnd;
    logic [DE-1:0] d_exp;
    logic          s_up;
    logic [SM:0]   s_rnd;
    logic [SE-1:0] s_exp;

    always_comb
    begin
        d_up  = s2_x_reg[DG] & ((|s2_x_reg[DG-1:0]) | s2_x_reg[DG+1]);
        d_rnd = {1'b0, s2_x_reg[W-2 -: DM]} + (DM+1)'(d_up);
        d_exp = DE'(i2f_pkg::DBL_BIAS + W - 1) - DE'(s2_n_reg) + DE'(d_rnd[DM]);

        s_up  = s2_x_reg[SG] & ((|s2_x_reg[SG-1:0]) | s2_x_reg[SG+1]);
        s_rnd = {1'b0, s2_x_reg[W-2 -: SM]} + (SM+1)'(s_up);
        s_exp = SE'(i2f_pkg::SGL_BIAS + W - 1) - SE'(s2_n_reg) + SE'(s_rnd[SM]);

        if (s2_single_reg)
        begin
            if (s2_zero_reg)
            begin
                float_bits_next = {32'b0, s2_neg_reg, 31'b0};
            end
            else
            begin
                float_bits_next = {32'b0, s2_neg_reg, s_exp, s_rnd[SM-1:0]};
            end
        end
        else
        begin
            if (s2_zero_reg)
            begin
                float_bits_next = {s2_neg_reg, 63'b0};
            end
            else
            begin
                float_bits_next = {s2_neg_reg, d_exp, d_rnd[DM-1:0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_neg_reg     <= in_item.neg;
        s1_single_reg  <= in_item.single;
        s1_zero_reg    <= (in_item.mag == '0);
        s1_x_reg       <= s1_x_next;
        s1_n_reg       <= s1_n_next;
        s2_neg_reg     <= s1_neg_reg;
        s2_single_reg  <= s1_single_reg;
        s2_zero_reg    <= s1_zero_reg;
        s2_x_reg       <= s2_x_next;
        s2_n_reg       <= s2_n_next;
        float_bits_reg <= float_bits_next;
    end

    assign done       = done_reg;
    assign float_bits = float_bits_reg;

    a_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_zero_reg) |-> s2_x_reg[W-1])
        else $error("magnitude not normalized after the fine shifts");

    a_single_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_single_reg) |=> (float_bits[W-1:32] == '0))
        else $error("binary32 result has upper bits set");

    a_zero_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_zero_reg) |-> !s2_neg_reg)
        else $error("zero magnitude flagged negative");

endmodule

>>> sv/int64_to_float_convert.sv
// Top level of the 64-bit integer to binary64/binary32 converter.
// Depends on i2f_pkg, i2f_front, i2f_queue and i2f_back.
//
// One conversion request is taken per clock cycle: a request is accepted at a
// rising edge with start high and busy low. The front end forms sign and
// magnitude and writes the request into a short queue; the back end takes one
// request per cycle from the queue and runs it through a three-stage pipeline
// (coarse normalize, fine normalize, round and pack). The result appears on
// float_bits with done high for exactly one cycle, once the request has passed
// through its queue entry and each pipeline stage register, in request
// order. Results cannot be held off by the receiver. Because the back end
// drains one request every cycle, the queue never holds more than one request
// at the full request rate, so it never fills and busy never rises.
module int64_to_float_convert #(
    parameter int QUEUE_DEPTH = i2f_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 func,
    input  logic [i2f_pkg::INT_W-1:0]  int_value,
    output logic                       done,
    output logic [i2f_pkg::INT_W-1:0]  float_bits
);

    i2f_pkg::i2f_item_t front_item;
    i2f_pkg::i2f_item_t head_item;
    logic               q_empty;
    logic               q_full;
    logic               push;
    logic               pop;

    assign busy = q_full;
    assign push = start & ~q_full;
    assign pop  = ~q_empty;

    i2f_front u_front (
        .func      (func),
        .int_value (int_value),
        .item      (front_item)
    );

    i2f_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head_item (head_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    i2f_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pop),
        .in_item    (head_item),
        .done       (done),
        .float_bits (float_bits)
    );

endmodule

>>> tb/int64_to_float_convert_checker.sv
`timescale 1ns / 1ps
// Checker for int64_to_float_convert: predicts each conversion and compares results.
// Depends on i2f_pkg for the mode encoding and the format widths.
module int64_to_float_convert_checker
    import i2f_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic [1:0]       func,
    input  logic [INT_W-1:0] int_value,
    input  logic             done,
    input  logic [INT_W-1:0] float_bits,
    output int               fail_count,
    output int               pending
);

    typedef struct {
        func_t            mode;
        logic [INT_W-1:0] operand;
        logic [INT_W-1:0] image;
    } conversion_t;

    conversion_t awaited_q[$];
    int          mismatches;

    assign fail_count = mismatches;

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    // Rounds the magnitude to nearest, ties to even, and adds the biased exponent
    // so that a carry out of the mantissa bumps the exponent.
    function automatic logic [INT_W-1:0] float_image(input func_t mode,
                                                     input logic [INT_W-1:0] raw);
        logic             neg;
        logic             single;
        logic [INT_W-1:0] mag;
        logic [INT_W-1:0] frac;
        logic [INT_W-1:0] keep;
        logic [INT_W-1:0] rem;
        logic [INT_W-1:0] half;
        logic [INT_W-1:0] expo;
        logic [INT_W-1:0] image;
        int               lz;
        int               mant_w;
        int               exp_w;
        int               bias;
        int               drop;
        single = (mode == FUNC_S_TO_S) || (mode == FUNC_U_TO_S);
        neg    = ((mode == FUNC_S_TO_D) || (mode == FUNC_S_TO_S)) && raw[INT_W-1];
        mag    = neg ? -raw : raw;
        mant_w = single ? SGL_MANT_W : DBL_MANT_W;
        exp_w  = single ? SGL_EXP_W : DBL_EXP_W;
        bias   = single ? SGL_BIAS : DBL_BIAS;
        image  = '0;
        if (mag != '0)
        begin
            lz = 0;
            while (!mag[INT_W-1-lz])
                lz++;
            frac = mag << lz;
            frac[INT_W-1] = 1'b0;
            drop = INT_W - 1 - mant_w;
            keep = frac >> drop;
            rem  = frac & ((64'd1 << drop) - 64'd1);
            half = 64'd1 << (drop - 1);
            if ((rem > half) || ((rem == half) && keep[0]))
                keep = keep + 64'd1;
            expo  = INT_W'(bias + INT_W - 1 - lz);
            image = (expo << mant_w) + keep;
        end
        if (neg)
            image[mant_w + exp_w] = 1'b1;
        return image;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        conversion_t req;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                req.mode    = func_t'(func);
                req.operand = int_value;
                req.image   = float_image(req.mode, int_value);
                awaited_q.push_back(req);
            end
            if (done)
            begin
                if (awaited_q.size() == 0)
                    report_mismatch($sformatf("unexpected result float_bits=%h", float_bits));
                else
                begin
                    req = awaited_q.pop_front();
                    if (float_bits !== req.image)
                        report_mismatch($sformatf("%s of %h: float_bits=%h, want %h",
                                                  req.mode.name(), req.operand,
                                                  float_bits, req.image));
                end
            end
            pending <= awaited_q.size();
        end
    end

endmodule

>>> tb/int64_to_float_convert_tb.sv
`timescale 1ns / 1ps
// Top of the int64_to_float_convert testbench: clock, reset, requests and verdict.
// Depends on i2f_pkg, the converter RTL and int64_to_float_convert_checker.
module int64_to_float_convert_tb;
    import i2f_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       func;
    logic [INT_W-1:0] int_value;
    logic             done;
    logic [INT_W-1:0] float_bits;
    int               fail_count;
    int               pending;
    int               idle_pct;
    int               cycles;

    int64_to_float_convert uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .int_value  (int_value),
        .done       (done),
        .float_bits (float_bits)
    );

    int64_to_float_convert_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .int_value  (int_value),
        .done       (done),
        .float_bits (float_bits),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Start stays high between back-to-back requests; it only drops while idling.
    task automatic send_request(input func_t mode, input logic [INT_W-1:0] operand);
        @(negedge clk);
        start     <= 1'b1;
        func      <= mode;
        int_value <= operand;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic drain_results;
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Biases operands toward short magnitudes, 32-bit sources and rounding ties.
    function automatic logic [INT_W-1:0] random_operand(input func_t mode);
        logic [INT_W-1:0] v;
        int               drop;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = v >> $urandom_range(0, 63);
            1: v = {{32{v[31]}}, v[31:0]};
            2: v = {32'd0, v[31:0]};
            3:
            begin
                drop = (mode == FUNC_S_TO_S || mode == FUNC_U_TO_S) ?
                       INT_W - 1 - SGL_MANT_W : INT_W - 1 - DBL_MANT_W;
                v = v >> $urandom_range(0, drop);
                v = v & ~((64'd1 << $urandom_range(1, drop)) - 64'd1);
                v = v | (64'd1 << $urandom_range(0, 12));
            end
            4: v = -(v >> $urandom_range(0, 63));
            default: ;
        endcase
        return v;
    endfunction

    initial
    begin
        func_t mode;
        int    phase;
        int    n;
        rst_n     = 1'b0;
        start     = 1'b0;
        func      = FUNC_S_TO_D;
        int_value = '0;
        idle_pct  = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_request(FUNC_S_TO_D, 64'd0);
        send_request(FUNC_U_TO_D, 64'd0);
        send_request(FUNC_S_TO_S, 64'd0);
        send_request(FUNC_U_TO_S, 64'd0);
        send_request(FUNC_S_TO_D, 64'd1);
        send_request(FUNC_S_TO_D, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(FUNC_U_TO_D, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(FUNC_S_TO_S, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(FUNC_U_TO_S, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(FUNC_S_TO_D, 64'h8000_0000_0000_0000);
        send_request(FUNC_S_TO_S, 64'h8000_0000_0000_0000);
        send_request(FUNC_U_TO_D, 64'h8000_0000_0000_0000);
        send_request(FUNC_S_TO_D, 64'h7FFF_FFFF_FFFF_FFFF);
        send_request(FUNC_S_TO_D, 64'h0020_0000_0000_0001);
        send_request(FUNC_S_TO_D, 64'h0020_0000_0000_0003);
        send_request(FUNC_S_TO_S, 64'h0000_0000_0100_0001);
        send_request(FUNC_U_TO_S, 64'h0000_0000_0100_0003);
        send_request(FUNC_U_TO_S, 64'h0000_0000_01FF_FFFF);
        send_request(FUNC_S_TO_S, 64'hFFFF_FFFF_8000_0000);
        send_request(FUNC_U_TO_S, 64'h0000_0000_FFFF_FFFF);
        send_request(FUNC_S_TO_S, 64'h0000_0000_7FFF_FFFF);
        drain_results();

        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1, 4: idle_pct = 79;
                2: idle_pct = 15;
                default: idle_pct = 0;
            endcase
            for (n = 0; n < 100; n++)
            begin
                mode = func_t'($urandom_range(0, 3));
                send_request(mode, random_operand(mode));
            end
            drain_results();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
